@@ hdl/pcbs_pkg.sv @@
// Package with the state type and shared constants of the per-class box suppression block.
`timescale 1ns / 1ps
package pcbs_pkg;

  localparam int unsigned CFG_IDX_BITS = 1;
  localparam int unsigned CFG_DATA_BITS = 17;
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_LABELS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_IOU_THRESHOLD = 1'd1;

  localparam int unsigned SCORE_BITS = 16;
  localparam int unsigned CLASS_BITS = 7;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EMIT,
    ST_CMP_AREA,
    ST_CMP_TEST,
    ST_NEXT_CLASS
  } state_t;

endpackage

@@ hdl/per_class_box_suppression.sv @@
// Top level of the per-class box suppression block: box store, sequencer and overlap unit.
`timescale 1ns / 1ps
// Usage: boxes arrive on the box channel (valid/ready), one per cycle, into a store
// of MAX_BOXES entries. The request marked final_box starts suppression; the block
// then drops ready until the pass is over. For each class from 0 to num_labels-1
// (num_labels capped at 128) the sequencer scans the store for the best live box
// (one entry per cycle), holds it as the pending result, then walks the store again,
// testing each live box of that class against it in the shared overlap unit
// (two steps per box: areas and intersection, then the scaled compare).
// A pending result is offered when the next kept box is chosen, or with
// end_of_list set when the pass closes. A class with no boxes costs one scan.
// The length of a pass is set by the one-entry-per-cycle scan and the single compare
// path of the overlap unit.
// The result register holds its request while the receiver stalls; the sequencer
// waits in place. Reset clears the store count, live flags and overflow flag, and
// sets the configuration registers (num_labels 80, iou_threshold 32768).
// Configuration writes are taken at any cycle through cfg_we/cfg_index/cfg_data.
module per_class_box_suppression
  import pcbs_pkg::*;
#(
  parameter int unsigned MAX_BOXES = 64,
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [COORD_BITS-1:0]    box_left,
  input  logic [COORD_BITS-1:0]    box_top,
  input  logic [COORD_BITS-1:0]    box_right,
  input  logic [COORD_BITS-1:0]    box_bottom,
  input  logic [SCORE_BITS-1:0]    score,
  input  logic [CLASS_BITS-1:0]    class_id,
  input  logic                     final_box,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [COORD_BITS-1:0]    kept_left,
  output logic [COORD_BITS-1:0]    kept_top,
  output logic [COORD_BITS-1:0]    kept_right,
  output logic [COORD_BITS-1:0]    kept_bottom,
  output logic [SCORE_BITS-1:0]    kept_score,
  output logic [CLASS_BITS-1:0]    kept_class,
  output logic                     overflowed,
  output logic                     end_of_list
);

  localparam int unsigned IDX_BITS = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CNT_BITS = $clog2(MAX_BOXES + 1);
  localparam int unsigned EXT_BITS = COORD_BITS;
  localparam int unsigned AREA_BITS = 2 * COORD_BITS;
  localparam int unsigned UNI_BITS = AREA_BITS + 1;
  localparam int unsigned PROD_BITS = UNI_BITS + 17;
  localparam int unsigned ENTRY_BITS = 4 * COORD_BITS + SCORE_BITS + CLASS_BITS;
  localparam logic [CNT_BITS-1:0] FULL = CNT_BITS'(MAX_BOXES);

  typedef struct packed {
    logic [COORD_BITS-1:0] l;
    logic [COORD_BITS-1:0] t;
    logic [COORD_BITS-1:0] r;
    logic [COORD_BITS-1:0] b;
    logic [SCORE_BITS-1:0] s;
    logic [CLASS_BITS-1:0] c;
  } entry_t;

  state_t state, state_next;

  logic [7:0]  num_labels;
  logic [16:0] iou_threshold;

  logic [CNT_BITS-1:0]   box_count;
  logic                  overflow_seen;
  logic [MAX_BOXES-1:0]  live_flags;

  logic [IDX_BITS-1:0]   ptr;         // scan or compare position
  logic [CLASS_BITS:0]   cur_class;
  logic                  best_found;
  logic [IDX_BITS-1:0]   best_idx;
  logic [SCORE_BITS-1:0] best_score;
  logic                  any_emitted;
  entry_t                best;

  // Registered-read store; the read address runs with ptr.
  logic                  wr_en;
  logic [IDX_BITS-1:0]   rd_addr;
  logic [ENTRY_BITS-1:0] rd_raw;
  entry_t                rd;
  entry_t                wr_entry;

  pcbs_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_BOXES)) u_store (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (box_count[IDX_BITS-1:0]),
    .wdata  (wr_entry),
    .raddr  (rd_addr),
    .rdata  (rd_raw)
  );
  assign rd = entry_t'(rd_raw);

  assign wr_entry = '{l: box_left, t: box_top, r: box_right, b: box_bottom,
                      s: score, c: class_id};

  // Output register and the kept box waiting to learn whether it is the last.
  entry_t out_q;
  entry_t pend;
  logic   out_ovf, out_eol;
  logic   out_load, out_load_eol;
  assign kept_left   = out_q.l;
  assign kept_top    = out_q.t;
  assign kept_right  = out_q.r;
  assign kept_bottom = out_q.b;
  assign kept_score  = out_q.s;
  assign kept_class  = out_q.c;
  assign overflowed  = out_ovf;
  assign end_of_list = out_eol;

  // Overlap unit: stage one forms extents, areas and intersection products.
  function automatic logic [EXT_BITS-1:0] ext(input logic [COORD_BITS-1:0] lo,
                                              input logic [COORD_BITS-1:0] hi);
    ext = (hi > lo) ? hi - lo : '0;
  endfunction

  logic [COORD_BITS-1:0] ix0, ix1, iy0, iy1;
  logic [AREA_BITS-1:0]  area_a, area_b, inter_c;
  logic [AREA_BITS-1:0]  area_q, inter_q;
  logic [UNI_BITS-1:0]   uni;
  logic [PROD_BITS-1:0]  lhs, rhs;
  logic                  kill;

  always_comb begin
    ix0 = (best.l > rd.l) ? best.l : rd.l;
    ix1 = (best.r < rd.r) ? best.r : rd.r;
    iy0 = (best.t > rd.t) ? best.t : rd.t;
    iy1 = (best.b < rd.b) ? best.b : rd.b;
    area_a  = AREA_BITS'(ext(rd.l, rd.r)) * AREA_BITS'(ext(rd.t, rd.b));
    inter_c = AREA_BITS'(ext(ix0, ix1)) * AREA_BITS'(ext(iy0, iy1));
  end

  // Area of the kept box is computed once when it is chosen.
  always_comb begin
    area_b = AREA_BITS'(ext(best.l, best.r)) * AREA_BITS'(ext(best.t, best.b));
  end

  logic [AREA_BITS-1:0] best_area;
  logic [IDX_BITS-1:0]  cmp_idx;
  logic                 cmp_live;

  always_comb begin
    uni  = UNI_BITS'(area_q) + UNI_BITS'(best_area) - UNI_BITS'(inter_q);
    lhs  = PROD_BITS'({inter_q, 16'd0});
    rhs  = PROD_BITS'(iou_threshold) * PROD_BITS'(uni);
    kill = (uni == '0) ? (iou_threshold == '0) : (lhs >= rhs);
  end

  logic [CLASS_BITS:0] labels;
  assign labels = (num_labels > 8'd128) ? 8'd128 : num_labels;

  logic out_free, pass_done;
  assign out_free = !out_valid || out_ready;
  assign pass_done = (cur_class >= labels) || (box_count == '0);

  logic last_ptr;
  assign last_ptr = (CNT_BITS'(ptr) + 1'b1 >= box_count);

  always_comb begin
    state_next = state;
    rd_addr = ptr;
    out_load = 1'b0;
    out_load_eol = 1'b0;
    unique case (state)
      ST_LOAD:      if (in_valid && final_box) state_next = ST_NEXT_CLASS;
      ST_NEXT_CLASS: begin
        rd_addr = '0;
        if (!pass_done) begin
          state_next = ST_SCAN;
        end else if (!any_emitted) begin
          state_next = ST_LOAD;
        end else if (out_free) begin
          // The pending box is the last one of the set.
          out_load = 1'b1;
          out_load_eol = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_SCAN: begin
        rd_addr = ptr + 1'b1;
        if (last_ptr) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        rd_addr = '0;
        if (!best_found) begin
          state_next = ST_NEXT_CLASS;
        end else if (out_free) begin
          out_load = any_emitted;
          state_next = ST_CMP_AREA;
        end
      end
      ST_CMP_AREA: state_next = ST_CMP_TEST;
      ST_CMP_TEST: begin
        rd_addr = ptr + 1'b1;
        if (last_ptr) state_next = ST_SCAN;
        else state_next = ST_CMP_AREA;
        if (last_ptr) rd_addr = '0;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  assign in_ready = (state == ST_LOAD);
  assign wr_en = in_ready && in_valid && (box_count < FULL);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q <= pend;
      out_ovf <= overflow_seen;
      out_eol <= out_load_eol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      num_labels <= 8'd80;
      iou_threshold <= 17'd32768;
      box_count <= '0;
      overflow_seen <= 1'b0;
      live_flags <= '0;
      ptr <= '0;
      cur_class <= '0;
      best_found <= 1'b0;
      any_emitted <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NUM_LABELS:    num_labels <= cfg_data[7:0];
          REG_IOU_THRESHOLD: iou_threshold <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_LOAD: begin
          if (in_valid) begin
            if (box_count < FULL) begin
              live_flags[box_count[IDX_BITS-1:0]] <= 1'b1;
              box_count <= box_count + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
            cur_class <= '0;
            any_emitted <= 1'b0;
          end
        end
        ST_NEXT_CLASS: begin
          ptr <= '0;
          best_found <= 1'b0;
          if (pass_done && state_next == ST_LOAD) begin
            // End of pass: clear the set.
            live_flags <= '0;
            box_count <= '0;
            overflow_seen <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (live_flags[ptr] && {1'b0, rd.c} == cur_class &&
              (!best_found || rd.s > best_score)) begin
            best_found <= 1'b1;
            best_idx <= ptr;
            best_score <= rd.s;
            best <= rd;
          end
          ptr <= last_ptr ? '0 : ptr + 1'b1;
        end
        ST_EMIT: begin
          if (!best_found) begin
            cur_class <= cur_class + 1'b1;
          end else if (out_free) begin
            // The previous kept box moves to the output register now.
            any_emitted <= 1'b1;
            pend <= best;
            live_flags[best_idx] <= 1'b0;
            best_area <= area_b;
            ptr <= '0;
          end
        end
        ST_CMP_AREA: begin
          area_q <= area_a;
          inter_q <= inter_c;
          cmp_idx <= ptr;
          cmp_live <= live_flags[ptr] && {1'b0, rd.c} == cur_class;
        end
        ST_CMP_TEST: begin
          if (cmp_live && kill) live_flags[cmp_idx] <= 1'b0;
          if (last_ptr) begin
            ptr <= '0;
            best_found <= 1'b0;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/pcbs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pcbs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ verif/per_class_box_suppression_tb.sv @@
// Self-checking testbench for the per-class box suppression block.
`timescale 1ns / 1ps
module per_class_box_suppression_tb;
  import pcbs_pkg::*;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned QUIET_CYCLES = 25000;

  typedef struct packed {
    logic [11:0] left;
    logic [11:0] top;
    logic [11:0] right;
    logic [11:0] bottom;
    logic [15:0] conf;
    logic [6:0]  label;
    logic        last;
  } box_req_t;

  typedef struct packed {
    logic [11:0] left;
    logic [11:0] top;
    logic [11:0] right;
    logic [11:0] bottom;
    logic [15:0] conf;
    logic [6:0]  label;
    logic        ovf;
    logic        eol;
  } kept_box_t;

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [11:0] box_left, box_top, box_right, box_bottom;
  logic [15:0] score;
  logic [6:0] class_id;
  logic final_box;
  logic [11:0] kept_left, kept_top, kept_right, kept_bottom;
  logic [15:0] kept_score;
  logic [6:0] kept_class;
  logic overflowed, end_of_list;

  per_class_box_suppression u_top (.*);

  // Stimulus, expectations and bookkeeping.
  box_req_t  pending_boxes[$];
  kept_box_t kept_expected[$];
  int send_idle_pct, recv_stall_pct;
  int errors, boxes_sent, boxes_kept, sets_closed;
  logic box_taken;

  // Predictor copy of the block state.
  logic [7:0]  labels_cfg;
  logic [16:0] thresh_cfg;
  box_req_t    held[STORE_DEPTH];
  bit          alive[STORE_DEPTH];
  int          held_count;
  bit          lost_box;

  function automatic longint unsigned span(logic [11:0] lo, logic [11:0] hi);
    return (hi > lo) ? longint'(hi - lo) : 0;
  endfunction

  function automatic bit suppresses(box_req_t a, box_req_t b);
    longint unsigned area_a, area_b, inter, uni;
    area_a = span(a.left, a.right) * span(a.top, a.bottom);
    area_b = span(b.left, b.right) * span(b.top, b.bottom);
    inter = span(a.left > b.left ? a.left : b.left, a.right < b.right ? a.right : b.right) *
            span(a.top > b.top ? a.top : b.top, a.bottom < b.bottom ? a.bottom : b.bottom);
    uni = area_a + area_b - inter;
    if (uni == 0) return thresh_cfg == 0;
    return (inter << 16) >= longint'(thresh_cfg) * uni;
  endfunction

  task automatic predict_box(box_req_t req);
    int top_n, best, kept_n;
    kept_box_t res;
    kept_box_t found[$];
    if (held_count < STORE_DEPTH) begin
      held[held_count] = req;
      alive[held_count] = 1;
      held_count++;
    end else begin
      lost_box = 1;
    end
    if (req.last) begin
      top_n = (labels_cfg > 128) ? 128 : labels_cfg;
      for (int k = 0; k < top_n; k++) begin
        forever begin
          best = -1;
          for (int i = 0; i < held_count; i++)
            if (alive[i] && held[i].label == k && (best < 0 || held[i].conf > held[best].conf))
              best = i;
          if (best < 0) break;
          alive[best] = 0;
          res = '{held[best].left, held[best].top, held[best].right, held[best].bottom,
                  held[best].conf, held[best].label, lost_box, 1'b0};
          found = {found, res};
          for (int i = 0; i < held_count; i++)
            if (alive[i] && held[i].label == k && suppresses(held[best], held[i]))
              alive[i] = 0;
        end
      end
      kept_n = found.size();
      if (kept_n > 0) found[kept_n-1].eol = 1;
      kept_expected = {kept_expected, found};
      for (int i = 0; i < STORE_DEPTH; i++) alive[i] = 0;
      held_count = 0;
      lost_box = 0;
      sets_closed++;
    end
  endtask

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Driver: a request holds until taken, then the next is offered unless idling.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (!in_valid || box_taken) begin
        if (pending_boxes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          {box_left, box_top, box_right, box_bottom, score, class_id, final_box} =
            pending_boxes.pop_front();
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Monitor: predicts on each taken request and checks each result.
  always @(posedge clk) begin
    kept_box_t got, want;
    box_taken <= in_valid && in_ready && !rst;
    if (!rst && in_valid && in_ready) begin
      predict_box({box_left, box_top, box_right, box_bottom, score, class_id, final_box});
      boxes_sent++;
    end
    if (!rst && out_valid && out_ready) begin
      got = '{kept_left, kept_top, kept_right, kept_bottom, kept_score, kept_class,
              overflowed, end_of_list};
      boxes_kept++;
      if (kept_expected.size() == 0) begin
        errors++;
        $display("%t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = kept_expected.pop_front();
        if (got.left !== want.left || got.top !== want.top || got.right !== want.right ||
            got.bottom !== want.bottom || got.conf !== want.conf ||
            got.label !== want.label || got.ovf !== want.ovf || got.eol !== want.eol) begin
          errors++;
          $display("%t: result mismatch, expected %h, actual %h", $time, want, got);
        end
      end
    end
  end

  task automatic add_box(int l, int t, int r, int b, int s, int c, bit last);
    box_req_t item;
    item = '{l[11:0], t[11:0], r[11:0], b[11:0], s[15:0], c[6:0], last};
    pending_boxes = {pending_boxes, item};
  endtask

  task automatic wait_idle();
    wait (pending_boxes.size() == 0 && !in_valid);
    wait (kept_expected.size() == 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == REG_NUM_LABELS) labels_cfg = val[7:0];
    else thresh_cfg = val;
  endtask

  // One set of boxes, mostly clustered so that suppression has work to do.
  task automatic add_set(int n);
    int cx, cy, w, h, l, t, prev_s, s, c, hint;
    hint = (labels_cfg == 0 || labels_cfg > 126) ? 127 : labels_cfg + 1;
    cx = $urandom_range(0, 4095);
    cy = $urandom_range(0, 4095);
    prev_s = $urandom_range(0, 65535);
    for (int i = 0; i < n; i++) begin
      s = ($urandom_range(0, 5) == 0) ? prev_s : $urandom_range(0, 65535);
      prev_s = s;
      c = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, hint);
      case ($urandom_range(0, 9))
        0: add_box($urandom, $urandom, $urandom, $urandom, s, c, i == n - 1);
        1: begin
          l = $urandom_range(1, 4095);
          t = $urandom_range(1, 4095);
          add_box(l, t, $urandom_range(0, l - 1), $urandom_range(0, t), s, c, i == n - 1);
        end
        2: begin
          l = $urandom_range(0, 4095);
          add_box(l, cy, l, cy + $urandom_range(0, 5), s, c, i == n - 1);
        end
        default: begin
          w = $urandom_range(1, 300);
          h = $urandom_range(1, 300);
          l = cx + $urandom_range(0, 40) - 20;
          t = cy + $urandom_range(0, 40) - 20;
          l = (l < 0) ? 0 : (l > 4095 ? 4095 : l);
          t = (t < 0) ? 0 : (t > 4095 ? 4095 : t);
          add_box(l, t, (l + w > 4095) ? 4095 : l + w, (t + h > 4095) ? 4095 : t + h,
                  s, c, i == n - 1);
        end
      endcase
    end
  endtask

  task automatic random_phase(int items, int idle_pct, int stall_pct);
    int n, queued;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    queued = 0;
    while (queued < items) begin
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
      add_set(n);
      queued += n;
    end
    wait_idle();
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_NUM_LABELS;
    cfg_data = '0;
    in_valid = 0;
    out_ready = 0;
    box_left = '0; box_top = '0; box_right = '0; box_bottom = '0;
    score = '0; class_id = '0; final_box = 0;
    box_taken = 0;
    errors = 0; boxes_sent = 0; boxes_kept = 0; sets_closed = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    labels_cfg = 80; thresh_cfg = 32768;
    held_count = 0; lost_box = 0;
    for (int i = 0; i < STORE_DEPTH; i++) alive[i] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: extremes, equal scores, inverted and zero-area boxes, dropped labels.
    add_box(0, 0, 4095, 4095, 65535, 0, 0);
    add_box(0, 0, 4095, 4095, 65535, 0, 0);
    add_box(10, 10, 20, 20, 0, 0, 0);
    add_box(4095, 4095, 0, 0, 100, 1, 0);
    add_box(5, 5, 5, 5, 100, 1, 0);
    add_box(100, 100, 200, 200, 500, 79, 0);
    add_box(100, 100, 200, 150, 500, 79, 0);
    add_box(0, 0, 1, 1, 7, 80, 0);
    add_box(0, 0, 1, 1, 7, 127, 1);
    add_box(1, 2, 3, 4, 9, 3, 1);
    wait_idle();
    random_phase(60, 0, 0);

    write_reg(REG_NUM_LABELS, 128);
    write_reg(REG_IOU_THRESHOLD, 65536);
    random_phase(90, 47, 0);
    write_reg(REG_NUM_LABELS, 1);
    write_reg(REG_IOU_THRESHOLD, 0);
    random_phase(90, 0, 47);
    write_reg(REG_NUM_LABELS, 255);
    write_reg(REG_IOU_THRESHOLD, 131071);
    random_phase(90, 15, 15);
    write_reg(REG_NUM_LABELS, 0);
    write_reg(REG_IOU_THRESHOLD, 20000);
    random_phase(30, 0, 0);
    write_reg(REG_NUM_LABELS, 8);
    write_reg(REG_IOU_THRESHOLD, 1000);
    random_phase(90, 15, 15);
    write_reg(REG_NUM_LABELS, 4);
    write_reg(REG_IOU_THRESHOLD, 45000);
    random_phase(90, 47, 47);

    if (kept_expected.size() != 0) begin
      errors++;
      $display("%t: %0d expected results never arrived", $time, kept_expected.size());
    end
    $display("Sent %0d boxes in %0d sets and checked %0d kept boxes", boxes_sent,
             sets_closed, boxes_kept);
    $display("Covered seven threshold and label settings under sender and receiver stalls");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pcbs_pkg.sv
hdl/per_class_box_suppression.sv
hdl/pcbs_ram.sv
verif/per_class_box_suppression_tb.sv
